/* design/process_list_push_find_delete_top_defines.svh */
// ----------------------------------------------------------------------------
// Process list assertion macros
// Shorthand for the clocked, reset-gated properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PROCESS_LIST_PUSH_FIND_DELETE_TOP_DEFINES_SVH
`define PROCESS_LIST_PUSH_FIND_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define PLIST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define PLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/plist_pkg.sv */
// ----------------------------------------------------------------------------
// Process list package
// Request codes and the control bundle shared by the list cells.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int REQ_W = 2;

  // Request kinds carried on s_tuser
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEL  = 2'd3;

  // What every cell does in a given cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,    // take the entry of the cell toward the head
    CELL_MATCH,   // compare against the search key
    CELL_PREFIX,  // OR in the match flag of a cell nearer the head
    CELL_LOAD,    // first matching cell copies its entry into the pick register
    CELL_GATHER,  // OR in the pick register of a cell farther from the head
    CELL_REMOVE   // cells at or past the hit take the entry of the next cell
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     pop;  // match the head cell instead of comparing ids
  } cell_ctrl_t;

endpackage

/* design/process_list_push_find_delete_top.sv */
// Push: goes from idle straight to the done state, which loads m_tdata once the output is free.
// Pop, find, delete: run the log-step prefix scan across the cell chain, load the
// first match into the pick registers, run the log-step data gather, apply any
// remove, then load m_tdata from the done state once the output is free.
// One request is in flight at a time; s_tready is high only when idle.
// Synchronous active-high rst empties the list and drops any pending result.
// ----------------------------------------------------------------------------
// Process list top
// Newest-first process list built as a chain of cells, with push, pop,
// find by id and delete by id.
// ----------------------------------------------------------------------------
module process_list_push_find_delete_top #(
  parameter int LIST_DEPTH = 16,
  parameter int ID_BITS    = 16,
  parameter int STATE_BITS = 8,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
  localparam int IN_W      = ((ID_BITS + STATE_BITS + 7) / 8) * 8,
  localparam int OUT_RAW   = 1 + ID_BITS + STATE_BITS + CNT_W + 2,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_W-1:0]              s_tdata,  // proc_id, proc_state, zero pad
  input  logic [plist_pkg::REQ_W-1:0]  s_tuser,  // req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit, out_id, out_state, entry_count, is_empty, overflow, zero pad
  output logic [OUT_W-1:0]             m_tdata
);

  localparam int LOG    = $clog2(LIST_DEPTH);
  localparam int STEP_W = (LOG > 1) ? $clog2(LOG) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_LOAD,
    S_GATHER,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                          fsm;
  logic [STEP_W-1:0]               step;
  logic [plist_pkg::REQ_W-1:0]     req;
  logic [CNT_W-1:0]                used_count;
  logic                            res_hit;
  logic [ID_BITS-1:0]              res_id;
  logic [STATE_BITS-1:0]           res_state;
  logic                            res_ovf;

  logic                            accept;
  logic                            full;
  logic                            step_last;
  logic                            hit_any;
  logic                            do_remove;
  logic [ID_BITS-1:0]              in_id;
  logic [STATE_BITS-1:0]           in_state;
  plist_pkg::cell_ctrl_t           ctrl;

  logic [ID_BITS-1:0]              c_id         [LIST_DEPTH];
  logic [STATE_BITS-1:0]           c_state      [LIST_DEPTH];
  logic                            c_valid      [LIST_DEPTH];
  logic                            c_pre        [LIST_DEPTH];
  logic [ID_BITS-1:0]              c_pick_id    [LIST_DEPTH];
  logic [STATE_BITS-1:0]           c_pick_state [LIST_DEPTH];

  assign in_id     = s_tdata[ID_BITS-1:0];
  assign in_state  = s_tdata[ID_BITS +: STATE_BITS];
  assign s_tready  = (fsm == S_IDLE) && !rst;
  assign accept    = s_tvalid & s_tready;
  assign full      = (used_count == CNT_W'(LIST_DEPTH));
  assign step_last = (step == STEP_W'(LOG - 1));
  assign hit_any   = c_pre[LIST_DEPTH-1];
  assign do_remove = (fsm == S_APPLY) && hit_any && (req != plist_pkg::REQ_FIND);

  // cell control for this cycle
  always_comb begin
    ctrl.op  = plist_pkg::CELL_HOLD;
    ctrl.pop = (s_tuser == plist_pkg::REQ_POP);
    case (fsm)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser != plist_pkg::REQ_PUSH) ctrl.op = plist_pkg::CELL_MATCH;
          else if (!full)                     ctrl.op = plist_pkg::CELL_PUSH;
        end
      end
      S_PREFIX: ctrl.op = plist_pkg::CELL_PREFIX;
      S_LOAD:   ctrl.op = plist_pkg::CELL_LOAD;
      S_GATHER: ctrl.op = plist_pkg::CELL_GATHER;
      S_APPLY:  if (do_remove) ctrl.op = plist_pkg::CELL_REMOVE;
      default:  ctrl.op = plist_pkg::CELL_HOLD;
    endcase
  end

  // cell chain, head at index 0
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]    l_id;
    logic [STATE_BITS-1:0] l_state;
    logic                  l_valid;
    logic [ID_BITS-1:0]    r_id;
    logic [STATE_BITS-1:0] r_state;
    logic                  r_valid;
    logic                  pre_far        [LOG];
    logic [ID_BITS-1:0]    pick_far_id    [LOG];
    logic [STATE_BITS-1:0] pick_far_state [LOG];

    if (i == 0) begin : g_head
      assign l_id    = in_id;
      assign l_state = in_state;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_id    = c_id[i-1];
      assign l_state = c_state[i-1];
      assign l_valid = c_valid[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign r_id    = '0;
      assign r_state = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_id    = c_id[i+1];
      assign r_state = c_state[i+1];
      assign r_valid = c_valid[i+1];
    end

    // neighbors at distance 2**k for the scan and gather steps
    for (genvar k = 0; k < LOG; k++) begin : g_far
      if (i >= (1 << k)) begin : g_pre
        assign pre_far[k] = c_pre[i - (1 << k)];
      end else begin : g_pre0
        assign pre_far[k] = 1'b0;
      end
      if (i + (1 << k) < LIST_DEPTH) begin : g_pick
        assign pick_far_id[k]    = c_pick_id[i + (1 << k)];
        assign pick_far_state[k] = c_pick_state[i + (1 << k)];
      end else begin : g_pick0
        assign pick_far_id[k]    = '0;
        assign pick_far_state[k] = '0;
      end
    end

    plist_cell #(
      .ID_BITS    (ID_BITS),
      .STATE_BITS (STATE_BITS),
      .LOG        (LOG),
      .STEP_W     (STEP_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .step           (step),
      .key            (in_id),
      .head           (i == 0),
      .left_id        (l_id),
      .left_state     (l_state),
      .left_valid     (l_valid),
      .right_id       (r_id),
      .right_state    (r_state),
      .right_valid    (r_valid),
      .pre_far        (pre_far),
      .pick_far_id    (pick_far_id),
      .pick_far_state (pick_far_state),
      .id             (c_id[i]),
      .state          (c_state[i]),
      .valid          (c_valid[i]),
      .pre            (c_pre[i]),
      .pick_id        (c_pick_id[i]),
      .pick_state     (c_pick_state[i])
    );
  end

  // sequencer, entry count, result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_IDLE;
      step       <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && fsm != S_DONE) m_tvalid <= 1'b0;
      case (fsm)
        S_IDLE: begin
          if (accept) begin
            req  <= s_tuser;
            step <= '0;
            if (s_tuser == plist_pkg::REQ_PUSH) begin
              res_hit   <= ~full;
              res_ovf   <= full;
              res_id    <= full ? '0 : in_id;
              res_state <= full ? '0 : in_state;
              if (!full) used_count <= used_count + 1'b1;
              fsm <= S_DONE;
            end else begin
              fsm <= S_PREFIX;
            end
          end
        end
        S_PREFIX: begin
          step <= step + 1'b1;
          if (step_last) fsm <= S_LOAD;
        end
        S_LOAD: begin
          step <= '0;
          fsm  <= S_GATHER;
        end
        S_GATHER: begin
          step <= step + 1'b1;
          if (step_last) fsm <= S_APPLY;
        end
        S_APPLY: begin
          res_hit   <= hit_any;
          res_ovf   <= 1'b0;
          res_id    <= c_pick_id[0];
          res_state <= c_pick_state[0];
          if (do_remove) used_count <= used_count - 1'b1;
          fsm <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({res_ovf, (used_count == '0), used_count,
                                res_state, res_id, res_hit});
            fsm      <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/plist_cell.sv */
// ----------------------------------------------------------------------------
// Process list cell
// One slot of the list: entry, valid bit, match prefix flag and pick register.
// ----------------------------------------------------------------------------
module plist_cell #(
  parameter int ID_BITS    = 16,
  parameter int STATE_BITS = 8,
  parameter int LOG        = 4,
  parameter int STEP_W     = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plist_pkg::cell_ctrl_t ctrl,
  input  logic [STEP_W-1:0]     step,
  input  logic [ID_BITS-1:0]    key,
  input  logic                  head,
  // neighbor toward the head (push source)
  input  logic [ID_BITS-1:0]    left_id,
  input  logic [STATE_BITS-1:0] left_state,
  input  logic                  left_valid,
  // neighbor away from the head (remove source)
  input  logic [ID_BITS-1:0]    right_id,
  input  logic [STATE_BITS-1:0] right_state,
  input  logic                  right_valid,
  // prefix flags 2**k cells toward the head, zero past the head
  input  logic                  pre_far [LOG],
  // pick registers 2**k cells away from the head, zero past the tail
  input  logic [ID_BITS-1:0]    pick_far_id [LOG],
  input  logic [STATE_BITS-1:0] pick_far_state [LOG],
  output logic [ID_BITS-1:0]    id,
  output logic [STATE_BITS-1:0] state,
  output logic                  valid,
  output logic                  pre,
  output logic [ID_BITS-1:0]    pick_id,
  output logic [STATE_BITS-1:0] pick_state
);

  logic first;

  // first match from the head: own prefix set, neighbor's not
  assign first = pre & ~pre_far[0];

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        plist_pkg::CELL_PUSH:   valid <= left_valid;
        plist_pkg::CELL_REMOVE: if (pre) valid <= right_valid;
        default:                valid <= valid;
      endcase
    end
  end

  // entry, prefix and pick payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      plist_pkg::CELL_PUSH: begin
        id    <= left_id;
        state <= left_state;
      end
      plist_pkg::CELL_MATCH: begin
        pre <= valid & (ctrl.pop ? head : (id == key));
      end
      plist_pkg::CELL_PREFIX: begin
        pre <= pre | pre_far[step];
      end
      plist_pkg::CELL_LOAD: begin
        pick_id    <= first ? id : '0;
        pick_state <= first ? state : '0;
      end
      plist_pkg::CELL_GATHER: begin
        pick_id    <= pick_id | pick_far_id[step];
        pick_state <= pick_state | pick_far_state[step];
      end
      plist_pkg::CELL_REMOVE: begin
        if (pre) begin
          id    <= right_id;
          state <= right_state;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/plist_checker.sv */
// ----------------------------------------------------------------------------
// Process list port checker
// Watches the stream ports of the process list and flags illegal behavior.
// ----------------------------------------------------------------------------
`include "process_list_push_find_delete_top_defines.svh"

module plist_checker #(
  parameter int LIST_DEPTH = 16,
  parameter int ID_BITS    = 16,
  parameter int STATE_BITS = 8,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
  localparam int OUT_RAW   = 1 + ID_BITS + STATE_BITS + CNT_W + 2,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [OUT_W-1:0]            m_tdata
);

  localparam int CNT_LSB   = 1 + ID_BITS + STATE_BITS;
  localparam int EMPTY_BIT = CNT_LSB + CNT_W;
  localparam int OVF_BIT   = EMPTY_BIT + 1;

  logic             out_hit;
  logic             out_empty;
  logic             out_ovf;
  logic [CNT_W-1:0] out_cnt;

  assign out_hit   = m_tdata[0];
  assign out_cnt   = m_tdata[CNT_LSB +: CNT_W];
  assign out_empty = m_tdata[EMPTY_BIT];
  assign out_ovf   = m_tdata[OVF_BIT];

  // stalled result beat holds
  `PLIST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // one request in flight: no back-to-back accept
  `PLIST_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready,
    "input accepted while a request is in flight")

  // refused push only on a full list, never with a hit
  `PLIST_ASSERT_IMPLY(a_ovf_full, m_tvalid && out_ovf,
    !out_hit && !out_empty && (out_cnt == CNT_W'(LIST_DEPTH)),
    "overflow reported on a list that is not full")

  // a new result appears only after input was held off
  `PLIST_ASSERT_IMPLY(a_result_after_busy, $rose(m_tvalid), $past(!s_tready),
    "result raised without a request in flight")

endmodule

bind process_list_push_find_delete_top plist_checker #(
  .LIST_DEPTH (LIST_DEPTH),
  .ID_BITS    (ID_BITS),
  .STATE_BITS (STATE_BITS)
) u_plist_checker (.*);

/* test/process_list_checker.sv */
// ----------------------------------------------------------------------------
// Process list result checker
// Watches the request and result streams of the process list. It keeps its
// own newest-first list and works out the result of each accepted request,
// then compares every returned beat field by field with the oldest pending
// result.
// ----------------------------------------------------------------------------
module process_list_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // proc_id, proc_state
  input  logic [plist_pkg::REQ_W-1:0] s_tuser,  // req_type
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // hit, out_id, out_state, entry_count, is_empty, overflow
  input  logic [31:0]                 m_tdata,
  output int                          due_count,
  output int                          failures,
  output int                          checked,
  output int                          hits,
  output int                          refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic [15:0] id;
    logic [7:0]  st;
    logic [4:0]  count;
    logic        empty;
    logic        ovf;
  } list_result_t;

  // Shadow list, slot 0 is the head
  logic [15:0]  held_id    [LIST_DEPTH];
  logic [7:0]   held_state [LIST_DEPTH];
  int           held_count;
  list_result_t results_due [$];
  int           fail_n, checked_n, hit_n, ovf_n;

  // Apply one request to the shadow list and return what the block must answer
  function automatic list_result_t run_request(logic [plist_pkg::REQ_W-1:0] req,
                                               logic [15:0] id, logic [7:0] st);
    list_result_t r;
    int           pos;
    r   = '0;
    pos = -1;
    case (req)
      plist_pkg::REQ_PUSH: begin
        if (held_count >= LIST_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          for (int i = held_count; i > 0; i--) begin
            held_id[i]    = held_id[i-1];
            held_state[i] = held_state[i-1];
          end
          held_id[0]    = id;
          held_state[0] = st;
          held_count++;
          r.hit = 1'b1;
          r.id  = id;
          r.st  = st;
        end
      end
      plist_pkg::REQ_POP: begin
        if (held_count > 0) pos = 0;
      end
      default: begin
        // find and delete act on the match nearest the head
        for (int i = 0; i < held_count; i++) begin
          if (pos < 0 && held_id[i] == id) pos = i;
        end
      end
    endcase
    if (pos >= 0) begin
      r.hit = 1'b1;
      r.id  = held_id[pos];
      r.st  = held_state[pos];
      if (req != plist_pkg::REQ_FIND) begin
        for (int i = pos; i < held_count - 1; i++) begin
          held_id[i]    = held_id[i+1];
          held_state[i] = held_state[i+1];
        end
        held_count--;
      end
    end
    r.count = held_count[4:0];
    r.empty = (held_count == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_n++;
    end
  endtask

  // Result beats are checked before the request beat of the same edge
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held_count = 0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result beat 0x%08h with no request pending", m_tdata);
          fail_n++;
        end else begin
          want = results_due.pop_front();
          checked_n++;
          check_field("hit",         int'(want.hit),   int'(m_tdata[0]));
          check_field("out_id",      int'(want.id),    int'(m_tdata[16:1]));
          check_field("out_state",   int'(want.st),    int'(m_tdata[24:17]));
          check_field("entry_count", int'(want.count), int'(m_tdata[29:25]));
          check_field("is_empty",    int'(want.empty), int'(m_tdata[30]));
          check_field("overflow",    int'(want.ovf),   int'(m_tdata[31]));
          if (want.hit) hit_n++;
          if (want.ovf) ovf_n++;
        end
      end
      if (s_tvalid && s_tready)
        results_due.push_back(run_request(s_tuser, s_tdata[15:0], s_tdata[23:16]));
    end
    due_count <= results_due.size();
    failures  <= fail_n;
    checked   <= checked_n;
    hits      <= hit_n;
    refusals  <= ovf_n;
  end

endmodule

/* test/process_list_push_find_delete_top_test.sv */
// ----------------------------------------------------------------------------
// Process list testbench
// Drives push, pop, find and delete requests into the process list, first a
// directed set around the empty list, duplicate ids and misses, then random
// requests whose push share swings so the list fills past full and drains
// back to empty. Both streams idle in random bursts; the checker judges.
// ----------------------------------------------------------------------------
module process_list_push_find_delete_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 830;
  localparam int CALM_TAIL   = 80;
  localparam int DRAIN_WAIT  = 40;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [23:0]                 s_tdata  = '0;  // proc_id, proc_state
  logic [plist_pkg::REQ_W-1:0] s_tuser  = plist_pkg::REQ_PUSH;  // req_type
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  // hit, out_id, out_state, entry_count, is_empty, overflow
  logic [31:0]                 m_tdata;

  int          due_count, failures, checked, hits, refusals;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          sent = 0;
  logic [15:0] id_pool [8];

  process_list_push_find_delete_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  process_list_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .due_count (due_count),
    .failures  (failures),
    .checked   (checked),
    .hits      (hits),
    .refusals  (refusals)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct / 2) begin
      stall_left <= $urandom_range(1, 19);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One request beat; tvalid only drops when a gap follows
  task automatic send_request(input logic [plist_pkg::REQ_W-1:0] req,
                              input logic [15:0] id, input logic [7:0] st);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {st, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  initial begin
    logic [plist_pkg::REQ_W-1:0] req;
    logic [15:0]                 id;
    int                          push_bias;
    int                          pick;

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = 16'($urandom_range(0, 65535));
    push_bias = 50;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    stall_pct = 20;

    // Empty list, extremes, duplicates, misses
    send_request(plist_pkg::REQ_FIND, 16'h1234, 8'h00);
    send_request(plist_pkg::REQ_POP,  16'h0000, 8'hFF);
    send_request(plist_pkg::REQ_DEL,  16'h0000, 8'h00);
    send_request(plist_pkg::REQ_PUSH, 16'h0000, 8'h00);
    send_request(plist_pkg::REQ_PUSH, 16'hFFFF, 8'hFF);
    send_request(plist_pkg::REQ_PUSH, 16'hFFFF, 8'h5A);
    send_request(plist_pkg::REQ_FIND, 16'hFFFF, 8'h00);
    send_request(plist_pkg::REQ_FIND, 16'h7777, 8'h00);
    send_request(plist_pkg::REQ_DEL,  16'hFFFF, 8'h00);
    send_request(plist_pkg::REQ_FIND, 16'hFFFF, 8'h00);
    send_request(plist_pkg::REQ_DEL,  16'h8888, 8'h00);
    send_request(plist_pkg::REQ_DEL,  16'h0000, 8'h00);
    send_request(plist_pkg::REQ_POP,  16'h0000, 8'h00);
    send_request(plist_pkg::REQ_POP,  16'h0000, 8'h00);
    send_request(plist_pkg::REQ_PUSH, 16'hAAAA, 8'h55);
    send_request(plist_pkg::REQ_PUSH, 16'h5555, 8'hAA);
    send_request(plist_pkg::REQ_DEL,  16'h5555, 8'h00);
    send_request(plist_pkg::REQ_FIND, 16'hAAAA, 8'h00);
    send_request(plist_pkg::REQ_POP,  16'hFFFF, 8'hFF);

    // Random requests; the push share and idling change every 40 beats
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        pick = $urandom_range(0, 2);
        push_bias = (n == 0) ? 90 : (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
        pick = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      end
      if (n >= RANDOM_REQS - CALM_TAIL) stall_pct = 0;
      if ($urandom_range(0, 99) < push_bias) req = plist_pkg::REQ_PUSH;
      else begin
        pick = $urandom_range(0, 2);
        req = (pick == 0) ? plist_pkg::REQ_POP :
              (pick == 1) ? plist_pkg::REQ_FIND : plist_pkg::REQ_DEL;
      end
      // mostly a small id pool so finds and deletes hit, sometimes any id
      if ($urandom_range(0, 3) != 0) id = id_pool[3'($urandom_range(0, 7))];
      else id = 16'($urandom_range(0, 65535));
      send_request(req, id, 8'($urandom_range(0, 255)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests, checked %0d results: %0d hits, %0d pushes refused on full.",
             sent, checked, hits, refusals);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", failures);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", due_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* process_list_push_find_delete_top.f */
+incdir+design
design/plist_pkg.sv
design/plist_cell.sv
design/process_list_push_find_delete_top.sv
design/plist_checker.sv
test/process_list_checker.sv
test/process_list_push_find_delete_top_test.sv
